// File: src/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key-value cache
// Sizes, codes, controller commands and the capacity clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 31;
  localparam int OUT_W       = 32;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(16);
  localparam logic [OUT_W-1:0] MISS_VALUE  = {OUT_W{1'b1}};

  // register index of the capacity register (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

  // operation codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE
  } lkv_state_t;

  typedef struct packed {
    logic load_in;   // capture the input transaction
    logic match;     // register lookup and victim selection
    logic update;    // commit store and recency changes
    logic load_out;  // load the result register
  } lkv_cmd_t;

  typedef struct packed {
    logic is_put;
  } lkv_sts_t;

  // zero acts as one, values above the store size saturate
  function automatic logic [CMP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
    logic [CMP_W-1:0] w;
    w = CMP_W'(c);
    if (w == CMP_W'(0)) w = CMP_W'(1);
    if (w > CMP_W'(MAX_ENTRIES)) w = CMP_W'(MAX_ENTRIES);
    return w;
  endfunction

endpackage

`default_nettype wire

// File: src/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top: fully associative key-value cache, LRU replacement
// APB capacity register, controller and datapath.
// ----------------------------------------------------------------------------
// A get transaction (action 0) looks lookup_key up in every valid entry at
// once and returns one result: hit = 1 with the stored value, or hit = 0 with
// read_value = -1; a hit makes the entry most recent. A put transaction
// (action 1) returns nothing: on a hit it overwrites the value, on a miss it
// fills the lowest empty slot, or evicts the least recent entry once the
// number of entries reaches the capacity register (0 acts as 1, values above
// 16 saturate). Each transaction steps through capture, parallel key compare
// with victim select, and commit; a get holds in commit while the previous
// result has not been taken. The result sits in an output register, so the
// next transaction is accepted while it waits. The store is empty right after
// reset, with no clearing pass. Capacity lies at byte address 0; the user must
// write it only while the cache is idle, which the block does not enforce;
// lowering it below the current fill evicts one entry per missing put.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_top (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lkv_pkg::ADDR_W-1:0]        paddr,
  input  logic [lkv_pkg::DATA_W-1:0]        pwdata,
  output logic [lkv_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [lkv_pkg::KEY_W-1:0]         lookup_key,
  input  logic [lkv_pkg::VAL_W-1:0]         store_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic signed [lkv_pkg::OUT_W-1:0]  read_value
);

  logic [lkv_pkg::CAP_W-1:0] entries_in_use;
  logic                      cap_sel;
  lkv_pkg::lkv_cmd_t         cmd;
  lkv_pkg::lkv_sts_t         sts;

  // --- configuration register ---
  assign pready  = 1'b1;
  assign cap_sel = (paddr[2] == lkv_pkg::REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= lkv_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      entries_in_use <= pwdata[lkv_pkg::CAP_W-1:0];
    end
  end

  // unused address bits below the word offset are ignored
  assign prdata = cap_sel ? lkv_pkg::DATA_W'(entries_in_use) : '0;

  // --- sequencing ---
  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // --- entry store, compare and result register ---
  lkv_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .action         (action),
    .lookup_key     (lookup_key),
    .store_value    (store_value),
    .entries_in_use (entries_in_use),
    .hit            (hit),
    .read_value     (read_value)
  );

endmodule

`default_nettype wire

// File: src/lkv_dp.sv
// ----------------------------------------------------------------------------
// lkv_dp: datapath of the LRU key-value cache
// Entry store, parallel key compare, recency ranks and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  lkv_pkg::lkv_cmd_t              cmd,
  output lkv_pkg::lkv_sts_t              sts,
  input  logic                           action,
  input  logic [lkv_pkg::KEY_W-1:0]      lookup_key,
  input  logic [lkv_pkg::VAL_W-1:0]      store_value,
  input  logic [lkv_pkg::CAP_W-1:0]      entries_in_use,
  output logic                           hit,
  output logic signed [lkv_pkg::OUT_W-1:0] read_value
);

  localparam int N = lkv_pkg::MAX_ENTRIES;

  // captured transaction
  logic                       act_r;
  logic [lkv_pkg::KEY_W-1:0]  key_r;
  logic [lkv_pkg::VAL_W-1:0]  val_r;

  // entry store
  logic [N-1:0]               valid;
  logic [lkv_pkg::KEY_W-1:0]  keys   [N];
  logic [lkv_pkg::VAL_W-1:0]  values [N];
  logic [lkv_pkg::IDX_W-1:0]  rank   [N];
  logic [lkv_pkg::CNT_W-1:0]  count;

  // lookup results
  logic [N-1:0]               slot_sel;
  logic                       hit_r;
  logic                       full_r;
  logic [lkv_pkg::CNT_W-1:0]  old_rank;
  logic [lkv_pkg::VAL_W-1:0]  rd_val;

  logic [N-1:0]               match;
  logic [N-1:0]               lru;
  logic [N-1:0]               free;
  logic                       hit_now;
  logic                       full_now;
  logic [lkv_pkg::IDX_W-1:0]  hit_rank;
  logic [lkv_pkg::VAL_W-1:0]  hit_val;
  logic [lkv_pkg::CNT_W-1:0]  count_m1;

  assign count_m1 = count - lkv_pkg::CNT_W'(1);
  assign free     = ~valid & (valid + N'(1));   // lowest empty slot, one-hot

  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = valid[i] && (keys[i] == key_r);
      lru[i]   = valid[i] && (lkv_pkg::CNT_W'(rank[i]) == count_m1);
      hit_rank = hit_rank | (rank[i] & {lkv_pkg::IDX_W{match[i]}});
      hit_val  = hit_val | (values[i] & {lkv_pkg::VAL_W{match[i]}});
    end
    hit_now  = |match;
    full_now = lkv_pkg::CMP_W'(count) >= lkv_pkg::eff_cap(entries_in_use);
  end

  assign sts.is_put = (act_r == lkv_pkg::ACT_PUT);

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= action;
      key_r <= lookup_key;
      val_r <= store_value;
    end
    if (cmd.match) begin
      hit_r  <= hit_now;
      full_r <= full_now;
      rd_val <= hit_val;
      if (hit_now) begin
        slot_sel <= match;
        old_rank <= lkv_pkg::CNT_W'(hit_rank);
      end else if (full_now) begin
        slot_sel <= lru;
        old_rank <= count_m1;
      end else begin
        slot_sel <= free;
        old_rank <= count;
      end
    end
    if (cmd.update && sts.is_put) begin
      for (int i = 0; i < N; i++) begin
        if (slot_sel[i]) begin
          values[i] <= val_r;
          if (!hit_r) keys[i] <= key_r;
        end
      end
    end
    if (cmd.load_out) begin
      hit        <= hit_r;
      read_value <= hit_r ? $signed({1'b0, rd_val}) : $signed(lkv_pkg::MISS_VALUE);
    end
  end

  // control state of the store
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < N; i++) rank[i] <= '0;
    end else if (cmd.update && (sts.is_put || hit_r)) begin
      for (int i = 0; i < N; i++) begin
        if (slot_sel[i]) begin
          rank[i] <= '0;
        end else if (valid[i] && (lkv_pkg::CNT_W'(rank[i]) < old_rank)) begin
          rank[i] <= rank[i] + lkv_pkg::IDX_W'(1);
        end
      end
      if (sts.is_put && !hit_r) begin
        valid <= valid | slot_sel;
        if (!full_r) count <= count + lkv_pkg::CNT_W'(1);
      end
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(count))
    else $error("entry count out of step with valid bits");

  a_update_one_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.update && sts.is_put |-> $onehot(slot_sel))
    else $error("put commits to other than exactly one slot");

  a_keys_unique: assert property (@(posedge clk) disable iff (rst)
    cmd.match |-> $onehot0(match))
    else $error("key held in more than one valid entry");

endmodule

`default_nettype wire

// File: src/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl: sequencing controller of the LRU key-value cache
// Steps each transaction through capture, lookup and commit.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output lkv_pkg::lkv_cmd_t  cmd,
  input  lkv_pkg::lkv_sts_t  sts
);

  lkv_pkg::lkv_state_t state, state_next;
  logic                out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkv_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      lkv_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = lkv_pkg::S_MATCH;
        end
      end
      lkv_pkg::S_MATCH: begin
        cmd.match  = 1'b1;
        state_next = lkv_pkg::S_UPDATE;
      end
      lkv_pkg::S_UPDATE: begin
        if (sts.is_put) begin
          cmd.update = 1'b1;
          state_next = lkv_pkg::S_IDLE;
        end else if (out_free) begin
          cmd.update   = 1'b1;
          cmd.load_out = 1'b1;
          state_next   = lkv_pkg::S_IDLE;
        end
      end
      default: state_next = lkv_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_accept_starts_lookup: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == lkv_pkg::S_MATCH)
    else $error("accepted transaction did not start a lookup");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("result loaded over an untaken result");

  a_result_leaves_on_ready: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without being taken");

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: LRU key-value cache, self-checking
// Drives get/put transactions with random idling on both channels, predicts
// every get result with a local LRU store and compares it field by field.
// Walks the capacity register through zero, one, small, full, saturated and
// out-of-range writes, including a capacity drop while the store is full.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CLK_HI        = 2;
  localparam int CLK_LO        = 2;
  localparam int RST_CYCLES    = 11;
  localparam int N_PHASE       = 10;
  localparam int PHASE_ITEMS   = 150;
  localparam int POOL_N        = 20;
  localparam int RX_HOLD       = 400;   // long receiver stall, in cycles
  localparam int HOLD_AFTER    = 60;    // transactions in before the stall starts
  localparam int SETTLE_CYCLES = 12;    // a put may still be committing
  localparam int TAIL_CYCLES   = 20;
  localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all

  // byte addresses: index 0 is the capacity register, index 1 is unmapped
  localparam logic [lkv_pkg::ADDR_W-1:0] ADDR_CAPACITY = {lkv_pkg::REG_CAPACITY, 2'b00};
  localparam logic [lkv_pkg::ADDR_W-1:0] ADDR_UNMAPPED = {~lkv_pkg::REG_CAPACITY, 2'b00};

  typedef struct {
    logic                      act;
    logic [lkv_pkg::KEY_W-1:0] k;
    logic [lkv_pkg::VAL_W-1:0] v;
  } cache_req_t;

  typedef struct {
    logic                             hit;
    logic signed [lkv_pkg::OUT_W-1:0] data;
  } lookup_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [lkv_pkg::ADDR_W-1:0]       paddr = '0;
  logic [lkv_pkg::DATA_W-1:0]       pwdata = '0;
  logic [lkv_pkg::DATA_W-1:0]       prdata;
  logic                             pready;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             action = lkv_pkg::ACT_GET;
  logic [lkv_pkg::KEY_W-1:0]        lookup_key = '0;
  logic [lkv_pkg::VAL_W-1:0]        store_value = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic                             hit;
  logic signed [lkv_pkg::OUT_W-1:0] read_value;

  lru_key_value_cache_top u_top (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .lookup_key  (lookup_key),
    .store_value (store_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .hit         (hit),
    .read_value  (read_value)
  );

  always begin
    #CLK_HI clk = 1'b1;
    #CLK_LO clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shared bookkeeping
  // --------------------------------------------------------------------------
  cache_req_t     req_queue[$];       // transactions waiting for the driver
  lookup_result_t expected_reads[$];  // predicted get results, oldest first
  logic [lkv_pkg::KEY_W-1:0] key_pool [POOL_N];
  logic           no_idle = 1'b0;     // set for phases that run back to back
  int             n_in = 0;
  int             n_out = 0;
  int             n_cfg = 0;
  int             errors = 0;

  // --------------------------------------------------------------------------
  // LRU store predictor
  // Own copy of the store; rank 0 is the most recent among valid slots.
  // --------------------------------------------------------------------------
  logic                      lru_valid [lkv_pkg::MAX_ENTRIES];
  logic [lkv_pkg::KEY_W-1:0] lru_key   [lkv_pkg::MAX_ENTRIES];
  logic [lkv_pkg::VAL_W-1:0] lru_val   [lkv_pkg::MAX_ENTRIES];
  logic [lkv_pkg::IDX_W-1:0] lru_rank  [lkv_pkg::MAX_ENTRIES];
  logic [lkv_pkg::CAP_W-1:0] lru_cap = lkv_pkg::CAP_RESET;

  task automatic lru_clear();
    for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) begin
      lru_valid[i] = 1'b0;
      lru_key[i]   = '0;
      lru_val[i]   = '0;
      lru_rank[i]  = '0;
    end
  endtask

  // move slot s to the front; everything that ranked ahead of it slides back
  task automatic lru_promote(input int s, input int old_rank);
    for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
      if (i != s && lru_valid[i] && int'(lru_rank[i]) < old_rank)
        lru_rank[i] = lru_rank[i] + 1'b1;
    lru_rank[s] = '0;
  endtask

  task automatic lru_access(input cache_req_t q);
    int             slot;
    int             fill;
    int             limit;
    int             old_rank;
    lookup_result_t r;
    slot = -1;
    for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
      if (slot < 0 && lru_valid[i] && lru_key[i] == q.k) slot = i;

    if (q.act == lkv_pkg::ACT_GET) begin
      if (slot >= 0) begin
        lru_promote(slot, int'(lru_rank[slot]));
        r.hit  = 1'b1;
        r.data = {1'b0, lru_val[slot]};
      end else begin
        r.hit  = 1'b0;
        r.data = lkv_pkg::MISS_VALUE;
      end
      expected_reads.push_back(r);
    end else if (slot >= 0) begin
      lru_val[slot] = q.v;
      lru_promote(slot, int'(lru_rank[slot]));
    end else begin
      fill = 0;
      for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++) if (lru_valid[i]) fill++;
      // zero acts as one, anything above the store size saturates
      limit = int'(lru_cap);
      if (limit == 0) limit = 1;
      if (limit > lkv_pkg::MAX_ENTRIES) limit = lkv_pkg::MAX_ENTRIES;
      if (fill >= limit) begin
        // one eviction only, even when the fill sits above a lowered capacity
        old_rank = 0;
        for (int i = 0; i < lkv_pkg::MAX_ENTRIES; i++)
          if (lru_valid[i] && (slot < 0 || int'(lru_rank[i]) > old_rank)) begin
            slot     = i;
            old_rank = int'(lru_rank[i]);
          end
      end else begin
        old_rank = fill;
        for (int i = lkv_pkg::MAX_ENTRIES - 1; i >= 0; i--) if (!lru_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        lru_valid[slot] = 1'b1;
        lru_key[slot]   = q.k;
        lru_val[slot]   = q.v;
        lru_promote(slot, old_rank);
      end
    end
  endtask

  // mostly short gaps, a few long ones; none in back-to-back phases
  function automatic int idle_len();
    int r;
    r = $urandom_range(99, 0);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents one transaction at a time, predicts on acceptance
  // --------------------------------------------------------------------------
  int tx_gap = 0;

  always @(posedge clk) begin
    cache_req_t q;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
      lru_clear();
    end else begin
      if (in_valid && in_ready) begin
        q.act = action;
        q.k   = lookup_key;
        q.v   = store_value;
        lru_access(q);
        n_in <= n_in + 1;
      end
      // free to change the payload only when nothing is pending on the port
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          q = req_queue.pop_front();
          in_valid    <= 1'b1;
          action      <= q.act;
          lookup_key  <= q.k;
          store_value <= q.v;
          tx_gap      <= idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result transaction, drives out_ready.
  // One long hold-off once the input side is busy, so the cache backs up.
  // --------------------------------------------------------------------------
  int   rx_gap = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    lookup_result_t e;
    int             bad;
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap    <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      bad = 0;
      if (out_valid && out_ready) begin
        if (expected_reads.size() == 0) begin
          $display("%0t: result with none expected: expected none, actual hit=%0b read_value=%0d",
                   $time, hit, read_value);
          bad++;
        end else begin
          e = expected_reads.pop_front();
          if (hit !== e.hit) begin
            $display("%0t: hit mismatch: expected %0b, actual %0b", $time, e.hit, hit);
            bad++;
          end
          if (read_value !== e.data) begin
            $display("%0t: read_value mismatch: expected %0d, actual %0d",
                     $time, e.data, read_value);
            bad++;
          end
        end
        n_out <= n_out + 1;
      end
      if (bad != 0) errors <= errors + bad;

      if (!hold_done && n_in >= HOLD_AFTER) begin
        hold_left <= RX_HOLD;
        hold_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap    <= rx_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_gap    <= idle_len();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any handshake ends the run
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration writes (only while the cache is idle)
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [lkv_pkg::ADDR_W-1:0] a,
                           input logic [lkv_pkg::DATA_W-1:0] d);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // only index 0 exists; the register keeps the low five bits
    if (a[2] == lkv_pkg::REG_CAPACITY) lru_cap = d[lkv_pkg::CAP_W-1:0];
    n_cfg++;
  endtask

  // sender pause: nothing queued, nothing on the port, every result back,
  // then a settling wait for a put that may still be committing
  task automatic wait_drained();
    @(negedge clk);
    while (req_queue.size() != 0 || in_valid || expected_reads.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic cache_req_t mk_req(input logic a, input logic [lkv_pkg::KEY_W-1:0] k,
                                        input logic [lkv_pkg::VAL_W-1:0] v);
    cache_req_t q;
    q.act = a;
    q.k   = k;
    q.v   = v;
    return q;
  endfunction

  function automatic cache_req_t rand_req();
    cache_req_t q;
    int         r;
    q.act = ($urandom_range(1, 0) == 1) ? lkv_pkg::ACT_PUT : lkv_pkg::ACT_GET;
    // mostly a small key set so that hits, updates and evictions happen
    if ($urandom_range(99, 0) < 85) q.k = key_pool[$urandom_range(POOL_N - 1, 0)];
    else q.k = $urandom;
    r = $urandom_range(19, 0);
    if (r == 0) q.v = '0;
    else if (r == 1) q.v = '1;
    else q.v = lkv_pkg::VAL_W'($urandom);
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [lkv_pkg::ADDR_W-1:0] cfg_addr;
    logic [lkv_pkg::DATA_W-1:0] cfg_data;

    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset capacity
    @(negedge clk);
    req_queue.push_back(mk_req(lkv_pkg::ACT_GET, 32'h0000_0001, '0)); // get on empty store
    req_queue.push_back(mk_req(lkv_pkg::ACT_PUT, '0, '0));            // lowest key, zero value
    req_queue.push_back(mk_req(lkv_pkg::ACT_PUT, '1, '1));            // highest key, top value
    req_queue.push_back(mk_req(lkv_pkg::ACT_GET, '0, '1));
    req_queue.push_back(mk_req(lkv_pkg::ACT_GET, '1, '0));
    req_queue.push_back(mk_req(lkv_pkg::ACT_GET, 32'h8000_0000, '1)); // miss
    req_queue.push_back(mk_req(lkv_pkg::ACT_PUT, '0, 31'h5555_5555)); // update in place
    req_queue.push_back(mk_req(lkv_pkg::ACT_GET, '0, '0));
    for (int i = 0; i < lkv_pkg::MAX_ENTRIES - 2; i++)                // fill to capacity
      req_queue.push_back(mk_req(lkv_pkg::ACT_PUT, 32'h0000_0100 + i,
                                 lkv_pkg::VAL_W'(i + 1)));
    req_queue.push_back(mk_req(lkv_pkg::ACT_PUT, 32'hDEAD_0000, 31'h2AAA_AAAA)); // evicts LRU
    req_queue.push_back(mk_req(lkv_pkg::ACT_GET, '1, '0));            // the evicted key
    req_queue.push_back(mk_req(lkv_pkg::ACT_GET, '0, '0));

    for (int ph = 0; ph < N_PHASE; ph++) begin
      wait_drained();
      cfg_addr = ADDR_CAPACITY;
      case (ph)
        0: cfg_data = 32'd0;             // zero acts as one
        1: cfg_data = 32'd31;            // saturates to the store size
        2: begin                         // unmapped index, ignored
          cfg_addr = ADDR_UNMAPPED;
          cfg_data = 32'd2;
        end
        3: cfg_data = 32'd16;
        4: cfg_data = 32'hFFFF_FFE3;     // drop to three while full, upper bits dropped
        5: cfg_data = 32'd1;
        6: cfg_data = 32'd8;
        7: cfg_data = 32'd17;
        8: cfg_data = 32'd2;
        default: cfg_data = 32'd12;
      endcase
      apb_write(cfg_addr, cfg_data);

      @(negedge clk);
      no_idle = (ph == 3 || ph == 7);
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom;
      for (int j = 0; j < PHASE_ITEMS; j++) req_queue.push_back(rand_req());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("summary: %0d transactions in, %0d get results checked, %0d register writes",
             n_in, n_out, n_cfg);
    $display("summary: capacity 0, 1, 2, 3, 8, 12, 16, 17, 31 and an unmapped write covered");
    if (errors == 0 && expected_reads.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0t: %0d mismatches, %0d results never arrived",
               $time, errors, expected_reads.size());
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
src/lkv_pkg.sv
src/lkv_dp.sv
src/lkv_ctrl.sv
src/lru_key_value_cache_top.sv
dv/testbench.sv
